@@ src/gss_pkg.sv @@
// Shared types, register codes and reset values of the Gray-Scott stencil step.
package gss_pkg;

  localparam int DATA_W  = 20;
  localparam int COEF_W  = 16;
  localparam int DT_W    = 18;
  localparam int GRID_W  = 11;
  localparam int POS_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KILL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd6;

  // reset values
  localparam logic [COEF_W-1:0] RST_DIFF_U = 16'd6554;
  localparam logic [COEF_W-1:0] RST_DIFF_V = 16'd3277;
  localparam logic [COEF_W-1:0] RST_FEED   = 16'd918;
  localparam logic [COEF_W-1:0] RST_KILL   = 16'd3539;
  localparam logic [DT_W-1:0]   RST_DT     = 18'd65536;
  localparam logic [GRID_W-1:0] RST_GRID   = 11'd1024;

  typedef struct packed {
    logic signed [DATA_W-1:0] cell_u;
    logic signed [DATA_W-1:0] cell_v;
  } gss_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_u;
    logic signed [DATA_W-1:0] new_v;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_column;
    logic                     frame_end;
  } gss_out_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;   // take the request, issue line store read
    logic             shift;     // shift windows, write line store
    logic             load_out;  // load result register
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last;
  } gss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
  } gss_status_t;

endpackage

@@ src/gss_ram.sv @@
// Generic single-port-write RAM with registered read.
module gss_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gss_ctrl.sv @@
// Sequencer of the Gray-Scott stencil step: positions, grid size and step timing.
module gss_ctrl
  import gss_pkg::*;
#(
  parameter int COLUMNS_MAX = 1024,
  parameter int ROWS_MAX    = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           out_ready_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  gss_status_t                    status_i,
  output gss_cmd_t                       cmd_o,
  output logic [$clog2(COLUMNS_MAX)-1:0] addr_o
);

  localparam int CPW = $clog2(COLUMNS_MAX);
  localparam int RPW = $clog2(ROWS_MAX);
  localparam int CW  = $clog2(COLUMNS_MAX + 1);
  localparam int RW  = $clog2(ROWS_MAX + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  localparam logic [2:0] CALC_LAST = 3'd6;

  logic [1:0]        state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [GRID_W-1:0] cols_q, rows_q;
  logic [CPW-1:0]    col_q, col_d;
  logic [RPW-1:0]    row_q, row_d;
  logic [CPW-1:0]    addr_q;
  logic [POS_W-1:0]  mrow_q, mcol_q;
  logic              last_q, inner_q;

  logic [CW-1:0]  cols_eff;
  logic [RW-1:0]  rows_eff;
  logic [CPW-1:0] c_cur;
  logic [RPW-1:0] r_cur;
  logic [31:0]    tmp_c, tmp_r, cg, rg;
  logic           accept;

  always_comb begin
    cg = 32'(cols_q);
    rg = 32'(rows_q);
    if (cg < 32'd3) begin
      cols_eff = CW'(3);
    end else if (cg > 32'(COLUMNS_MAX)) begin
      cols_eff = CW'(COLUMNS_MAX);
    end else begin
      cols_eff = CW'(cg);
    end
    if (rg < 32'd3) begin
      rows_eff = RW'(3);
    end else if (rg > 32'(ROWS_MAX)) begin
      rows_eff = RW'(ROWS_MAX);
    end else begin
      rows_eff = RW'(rg);
    end
    // positions beyond the grid restart at zero
    c_cur = (32'(col_q) >= 32'(cols_eff)) ? '0 : col_q;
    r_cur = (32'(row_q) >= 32'(rows_eff)) ? '0 : row_q;
    tmp_c = 32'(c_cur) - 32'd1;
    tmp_r = 32'(r_cur) - 32'd1;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (32'(c_cur) + 32'd1 >= 32'(cols_eff)) begin
        col_d = '0;
        if (32'(r_cur) + 32'd1 >= 32'(rows_eff)) begin
          row_d = '0;
        end else begin
          row_d = r_cur + RPW'(1);
        end
      end else begin
        col_d = c_cur + CPW'(1);
        row_d = r_cur;
      end
    end
    if (cfg_we_i && (cfg_index_i == REG_COLS || cfg_index_i == REG_ROWS)) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cnt_d   = '0;
        state_d = inner_q ? S_CALC : S_IDLE;
      end
      S_CALC: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == CALC_LAST) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!status_i.out_valid || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cols_q  <= RST_GRID;
      rows_q  <= RST_GRID;
      col_q   <= '0;
      row_q   <= '0;
      inner_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i && cfg_index_i == REG_COLS) begin
        cols_q <= cfg_data_i[GRID_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == REG_ROWS) begin
        rows_q <= cfg_data_i[GRID_W-1:0];
      end
      if (accept) begin
        inner_q <= (32'(r_cur) >= 32'd2) && (32'(c_cur) >= 32'd2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= c_cur;
      mrow_q <= tmp_r[POS_W-1:0];
      mcol_q <= tmp_c[POS_W-1:0];
      last_q <= (32'(r_cur) == 32'(rows_eff) - 32'd1) &&
                (32'(c_cur) == 32'(cols_eff) - 32'd1);
    end
  end

  assign addr_o = (state_q == S_IDLE) ? c_cur : addr_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.shift    = (state_q == S_FETCH);
    cmd_o.load_out = (state_q == S_HOLD) && (!status_i.out_valid || out_ready_i);
    cmd_o.row      = mrow_q;
    cmd_o.column   = mcol_q;
    cmd_o.last     = last_q;
  end

`ifndef SYNTHESIS
  a_fetch_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> $past(in_valid_i && in_ready_o))
    else $error("fetch without accepted request");
  a_calc_to_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC && cnt_q == CALC_LAST) |=> (state_q == S_HOLD))
    else $error("calculation did not end in hold");
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i) |=> (32'(col_q) < 32'(cols_eff)))
    else $error("column position left the grid");
`endif

endmodule

@@ src/gss_datapath.sv @@
// Line store, 3x3 windows and Gray-Scott update arithmetic.
module gss_datapath
  import gss_pkg::*;
#(
  parameter int COLUMNS_MAX   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gss_in_t                        in_data_i,
  input  logic                           out_ready_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  gss_cmd_t                       cmd_i,
  input  logic [$clog2(COLUMNS_MAX)-1:0] addr_i,
  output gss_status_t                    status_o,
  output gss_out_t                       out_data_o
);

  localparam int FB      = FRACTION_BITS;
  localparam int LAP_W   = DATA_W + 4;
  localparam int VV_W    = 2 * DATA_W;
  localparam int PROD_W  = 3 * DATA_W + 1;
  localparam int UVV_SH  = 2 * FB - 16;
  localparam int UVV_W   = PROD_W - UVV_SH;
  localparam int OMU_W   = ((FB > DATA_W - 1) ? FB : DATA_W - 1) + 2;
  localparam int FT_W    = OMU_W + COEF_W + 1;
  localparam int DL_W    = LAP_W + COEF_W + 1;
  localparam int FK_W    = DATA_W + COEF_W + 2;
  localparam int M1_W    = (DL_W > UVV_W) ? DL_W : UVV_W;
  localparam int M2_W    = (FT_W > FK_W) ? FT_W : FK_W;
  localparam int ACC_W   = ((M1_W > M2_W) ? M1_W : M2_W) + 2;
  localparam int DEL_W   = ACC_W - 16;
  localparam int MD_W    = DEL_W + DT_W + 1;
  localparam int RES_W   = MD_W - 16 + 2;
  localparam int RAM_W   = 4 * DATA_W;

  localparam logic signed [PROD_W-1:0] UVV_HALF = (PROD_W'(1) << UVV_SH) >> 1;
  localparam logic signed [OMU_W-1:0]  ONE      = OMU_W'(1) << FB;
  localparam logic signed [ACC_W-1:0]  HALF_A   = ACC_W'(1) << 15;
  localparam logic signed [MD_W-1:0]   HALF_M   = MD_W'(1) << 15;
  localparam logic signed [RES_W-1:0]  SAT_MAX  = RES_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [RES_W-1:0]  SAT_MIN  = -RES_W'(1 << (DATA_W - 1));

  // configuration
  logic [COEF_W-1:0] du_q, dv_q, feed_q, kill_q;
  logic [DT_W-1:0]   dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      du_q   <= RST_DIFF_U;
      dv_q   <= RST_DIFF_V;
      feed_q <= RST_FEED;
      kill_q <= RST_KILL;
      dt_q   <= RST_DT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DIFF_U: du_q   <= cfg_data_i[COEF_W-1:0];
        REG_DIFF_V: dv_q   <= cfg_data_i[COEF_W-1:0];
        REG_FEED:   feed_q <= cfg_data_i[COEF_W-1:0];
        REG_KILL:   kill_q <= cfg_data_i[COEF_W-1:0];
        REG_DT:     dt_q   <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // line store: {u row above, u row, v row above, v row} per column
  logic [RAM_W-1:0] rd_data, wr_data;
  gss_in_t          cell_q;

  gss_ram #(.WIDTH(RAM_W), .DEPTH(COLUMNS_MAX)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (addr_i),
    .wdata_i (wr_data),
    .re_i    (cmd_i.capture),
    .raddr_i (addr_i),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cell_q <= in_data_i;
    end
  end

  assign wr_data = {rd_data[3*DATA_W-1:2*DATA_W], cell_q.cell_u,
                    rd_data[DATA_W-1:0], cell_q.cell_v};

  // windows, index 3*row + column, column 2 newest
  logic signed [DATA_W-1:0] uw_q [9];
  logic signed [DATA_W-1:0] vw_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        uw_q[k] <= '0;
        vw_q[k] <= '0;
      end
    end else if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        uw_q[3*k]   <= uw_q[3*k+1];
        uw_q[3*k+1] <= uw_q[3*k+2];
        vw_q[3*k]   <= vw_q[3*k+1];
        vw_q[3*k+1] <= vw_q[3*k+2];
      end
      uw_q[2] <= rd_data[4*DATA_W-1:3*DATA_W];
      uw_q[5] <= rd_data[3*DATA_W-1:2*DATA_W];
      uw_q[8] <= cell_q.cell_u;
      vw_q[2] <= rd_data[2*DATA_W-1:DATA_W];
      vw_q[5] <= rd_data[DATA_W-1:0];
      vw_q[8] <= cell_q.cell_v;
    end
  end

  logic signed [DATA_W-1:0] uc, vc;
  assign uc = uw_q[4];
  assign vc = vw_q[4];

  // stage 1: Laplacians, v*v, 1-u, feed+kill
  logic signed [LAP_W-1:0] lapu_q, lapv_q, lapu_d, lapv_d;
  logic signed [VV_W-1:0]  vv_q;
  logic signed [OMU_W-1:0] omu_q;
  logic [COEF_W:0]         fk_q;

  always_comb begin
    lapu_d = -(LAP_W'(uc) <<< 3);
    lapv_d = -(LAP_W'(vc) <<< 3);
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        lapu_d = lapu_d + LAP_W'(uw_q[k]);
        lapv_d = lapv_d + LAP_W'(vw_q[k]);
      end
    end
  end

  // stage 2: products
  logic signed [DL_W-1:0]       dul_q, dvl_q;
  logic signed [DATA_W+DATA_W:0] plo_q;
  logic signed [2*DATA_W-1:0]   phi_q;
  logic signed [FT_W-1:0]       ft_q;
  logic signed [FK_W-1:0]       fkv_q;
  // stage 3..7
  logic signed [PROD_W-1:0]     prod_q, uvv_t;
  logic signed [UVV_W-1:0]      uvv_q;
  logic signed [ACC_W-1:0]      accu_q, accv_q, ru_t, rv_t;
  logic signed [DEL_W-1:0]      delu_q, delv_q;
  logic signed [MD_W-1:0]       mdu_q, mdv_q, mu_t, mv_t;

  assign uvv_t = prod_q + UVV_HALF;
  assign ru_t  = accu_q + HALF_A;
  assign rv_t  = accv_q + HALF_A;
  assign mu_t  = mdu_q + HALF_M;
  assign mv_t  = mdv_q + HALF_M;

  always_ff @(posedge clk_i) begin
    lapu_q <= lapu_d;
    lapv_q <= lapv_d;
    vv_q   <= vc * vc;
    omu_q  <= ONE - OMU_W'(uc);
    fk_q   <= {1'b0, feed_q} + {1'b0, kill_q};

    dul_q  <= $signed({1'b0, du_q}) * lapu_q;
    dvl_q  <= $signed({1'b0, dv_q}) * lapv_q;
    plo_q  <= uc * $signed({1'b0, vv_q[DATA_W-1:0]});
    phi_q  <= uc * $signed(vv_q[VV_W-1:DATA_W]);
    ft_q   <= $signed({1'b0, feed_q}) * omu_q;
    fkv_q  <= $signed({1'b0, fk_q}) * vc;

    prod_q <= (PROD_W'(phi_q) <<< DATA_W) + PROD_W'(plo_q);
    uvv_q  <= UVV_W'(uvv_t >>> UVV_SH);

    accu_q <= ACC_W'(dul_q) - ACC_W'(uvv_q) + ACC_W'(ft_q);
    accv_q <= ACC_W'(dvl_q) + ACC_W'(uvv_q) - ACC_W'(fkv_q);

    delu_q <= DEL_W'(ru_t >>> 16);
    delv_q <= DEL_W'(rv_t >>> 16);

    mdu_q  <= delu_q * $signed({1'b0, dt_q});
    mdv_q  <= delv_q * $signed({1'b0, dt_q});
  end

  // final add and saturation
  logic signed [RES_W-1:0]  sumu, sumv;
  logic signed [DATA_W-1:0] satu, satv;

  always_comb begin
    sumu = RES_W'(uc) + RES_W'(mu_t >>> 16);
    sumv = RES_W'(vc) + RES_W'(mv_t >>> 16);
    if (sumu > SAT_MAX) begin
      satu = DATA_W'(SAT_MAX);
    end else if (sumu < SAT_MIN) begin
      satu = DATA_W'(SAT_MIN);
    end else begin
      satu = DATA_W'(sumu);
    end
    if (sumv > SAT_MAX) begin
      satv = DATA_W'(SAT_MAX);
    end else if (sumv < SAT_MIN) begin
      satv = DATA_W'(SAT_MIN);
    end else begin
      satv = DATA_W'(sumv);
    end
  end

  // result register
  logic     out_valid_q;
  gss_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.new_u      <= satu;
      out_q.new_v      <= satv;
      out_q.out_row    <= cmd_i.row;
      out_q.out_column <= cmd_i.column;
      out_q.frame_end  <= cmd_i.last;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign out_data_o         = out_q;

endmodule

@@ src/gray_scott_stencil_step_top.sv @@
// Top level of the Gray-Scott reaction-diffusion stencil step.
//
//  channel  direction  handshake                    payload
//  in       input      in_valid_i / in_ready_o      in_data_i  (cell_u, cell_v)
//  out      output     out_valid_o / out_ready_i    out_data_o (new_u, new_v, row, column, end)
//  cfg      input      cfg_we_i                     cfg_index_i, cfg_data_i
//
// A halo cell is accepted, reading the line store, and then shifts the windows; an
// interior cell also passes through the multiply and round stages of the shared
// update datapath and then loads the result register.
// A new request is accepted while a finished result waits in the output register;
// the step holds before loading that register until it is free.
// Reset clears positions, windows and sequencer; the line store is not cleared,
// since rows 0 and 1 of every frame write it before any result reads it.
module gray_scott_stencil_step_top
  import gss_pkg::*;
#(
  parameter int COLUMNS_MAX   = 1024,
  parameter int ROWS_MAX      = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gss_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gss_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  gss_cmd_t                       cmd;
  gss_status_t                    status;
  logic [$clog2(COLUMNS_MAX)-1:0] addr;

  // sequencer: positions, grid size, step timing
  gss_ctrl #(
    .COLUMNS_MAX (COLUMNS_MAX),
    .ROWS_MAX    (ROWS_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  // line store, windows, update arithmetic and result register
  gss_datapath #(
    .COLUMNS_MAX   (COLUMNS_MAX),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  assign out_valid_o = status.out_valid;

endmodule

@@ dv/gray_scott_stencil_step_top_tb.sv @@
// Self-checking testbench for the Gray-Scott stencil step top level.
module gray_scott_stencil_step_top_tb;
  import gss_pkg::*;

  localparam int COLS_MAX    = 1024;
  localparam int ROWS_MAX    = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 30;

  // Register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Idling modes, one per phase
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Expected-update store: mirrors the stencil step and queues the cell
  // updates that each request produces.
  class gs_scoreboard;
    gss_out_t        pending_updates[$];
    int              mismatches;
    longint          diff_u, diff_v, feed_coef, kill_coef, dt;
    int              grid_cols, grid_rows;
    longint          u_upper[COLS_MAX], u_lower[COLS_MAX];
    longint          v_upper[COLS_MAX], v_lower[COLS_MAX];
    longint          u_win[9], v_win[9];
    int              col_pos, row_pos;

    function new();
      diff_u = RST_DIFF_U; diff_v = RST_DIFF_V;
      feed_coef = RST_FEED; kill_coef = RST_KILL; dt = RST_DT;
      grid_cols = RST_GRID; grid_rows = RST_GRID;
      foreach (u_upper[i]) begin
        u_upper[i] = 0; u_lower[i] = 0; v_upper[i] = 0; v_lower[i] = 0;
      end
      foreach (u_win[i]) begin
        u_win[i] = 0; v_win[i] = 0;
      end
      col_pos = 0; row_pos = 0; mismatches = 0;
    endfunction

    // Round half up and drop 16 fraction bits
    function longint round16(longint x);
      return (x + 64'sd32768) >>> 16;
    endfunction

    function longint sat20(longint x);
      if (x > 524287) return 524287;
      if (x < -524288) return -524288;
      return x;
    endfunction

    function longint lap9(longint w[9]);
      longint s;
      s = 0;
      for (int k = 0; k < 9; k++) s += (k == 4) ? -8 * w[k] : w[k];
      return s;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DIFF_U: diff_u = val[15:0];
        REG_DIFF_V: diff_v = val[15:0];
        REG_FEED:   feed_coef = val[15:0];
        REG_KILL:   kill_coef = val[15:0];
        REG_DT:     dt = val;
        REG_COLS: begin
          grid_cols = val[10:0]; col_pos = 0; row_pos = 0;
        end
        REG_ROWS: begin
          grid_rows = val[10:0]; col_pos = 0; row_pos = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_cell(gss_in_t pair);
      int       cols, rows, c, r;
      longint   nu, nv, uc, vc, uvv, du, dv;
      gss_out_t upd;
      cols = (grid_cols < 3) ? 3 : (grid_cols > COLS_MAX) ? COLS_MAX : grid_cols;
      rows = (grid_rows < 3) ? 3 : (grid_rows > ROWS_MAX) ? ROWS_MAX : grid_rows;
      if (col_pos >= cols) col_pos = 0;
      if (row_pos >= rows) row_pos = 0;
      c = col_pos; r = row_pos;
      nu = longint'(pair.cell_u);
      nv = longint'(pair.cell_v);
      for (int k = 0; k < 3; k++) begin
        u_win[3*k] = u_win[3*k+1]; u_win[3*k+1] = u_win[3*k+2];
        v_win[3*k] = v_win[3*k+1]; v_win[3*k+1] = v_win[3*k+2];
      end
      u_win[2] = u_upper[c]; u_win[5] = u_lower[c]; u_win[8] = nu;
      v_win[2] = v_upper[c]; v_win[5] = v_lower[c]; v_win[8] = nv;
      u_upper[c] = u_lower[c]; u_lower[c] = nu;
      v_upper[c] = v_lower[c]; v_lower[c] = nv;
      if (r >= 2 && c >= 2) begin
        uc = u_win[4]; vc = v_win[4];
        uvv = round16(uc * vc * vc);
        du = round16(diff_u * lap9(u_win) - uvv + feed_coef * (65536 - uc));
        dv = round16(diff_v * lap9(v_win) + uvv - (feed_coef + kill_coef) * vc);
        upd.new_u      = DATA_W'(sat20(uc + round16(du * dt)));
        upd.new_v      = DATA_W'(sat20(vc + round16(dv * dt)));
        upd.out_row    = POS_W'(r - 1);
        upd.out_column = POS_W'(c - 1);
        upd.frame_end  = (r == rows - 1 && c == cols - 1);
        pending_updates.push_back(upd);
      end
      c++;
      if (c >= cols) begin
        c = 0;
        r++;
        if (r >= rows) r = 0;
      end
      col_pos = c; row_pos = r;
    endfunction

    function void check_update(gss_out_t got);
      gss_out_t exp_upd;
      if (pending_updates.size() == 0) begin
        $error("unexpected update row=%0d column=%0d", got.out_row, got.out_column);
        mismatches++;
        return;
      end
      exp_upd = pending_updates.pop_front();
      if (got.new_u !== exp_upd.new_u) begin
        $error("new_u expected %0d got %0d", exp_upd.new_u, got.new_u);
        mismatches++;
      end
      if (got.new_v !== exp_upd.new_v) begin
        $error("new_v expected %0d got %0d", exp_upd.new_v, got.new_v);
        mismatches++;
      end
      if (got.out_row !== exp_upd.out_row) begin
        $error("out_row expected %0d got %0d", exp_upd.out_row, got.out_row);
        mismatches++;
      end
      if (got.out_column !== exp_upd.out_column) begin
        $error("out_column expected %0d got %0d", exp_upd.out_column, got.out_column);
        mismatches++;
      end
      if (got.frame_end !== exp_upd.frame_end) begin
        $error("frame_end expected %0d got %0d", exp_upd.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  gss_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  gss_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gs_scoreboard sb = new();
  idle_mode_e   idle_mode = IDLE_NONE;
  int           phase_no = 0;
  int           cycles = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  gray_scott_stencil_step_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Cycle limit: end the run if the block hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Note every accepted request and check every accepted update
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_cell(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_update(out_data_o);
  end

  // Receiver: stall at random per mode; in phase 2 hold off once for a long
  // stretch so the block fills up and drops in_ready_o.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && phase_no == 2) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_ready_i <= ($urandom_range(99) >= 55);
        IDLE_BOTH: out_ready_i <= ($urandom_range(99) >= 6);
        default:   out_ready_i <= 1'b1;
      endcase
    end
  end

  // Offer one request; hold valid and payload until accepted
  task automatic send_cell(gss_in_t pair);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pair;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, drain all pending updates and let the tail of halo work finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return DATA_W'($urandom_range(70000));
    if (pick < 90) return DATA_W'($urandom);
    case ($urandom_range(3))
      0: return -20'sd524288;
      1: return 20'sd524287;
      2: return '0;
      default: return -20'sd1;
    endcase
  endfunction

  // Coefficient: extremes now and then, random otherwise
  function automatic logic [CFG_DATA_W-1:0] rand_coef(int width);
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_DATA_W'((1 << width) - 1);
    return CFG_DATA_W'($urandom_range((1 << width) - 1));
  endfunction

  task automatic send_frame_cells(int count);
    gss_in_t pair;
    for (int i = 0; i < count; i++) begin
      pair.cell_u = rand_value();
      pair.cell_v = rand_value();
      send_cell(pair);
    end
  endtask

  initial begin
    gss_in_t pair;
    int      cols, rows, sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 5x5 frame, largest coefficients, extreme cell values
    write_reg(REG_DIFF_U, 18'hFFFF);
    write_reg(REG_DIFF_V, 18'hFFFF);
    write_reg(REG_FEED, 18'hFFFF);
    write_reg(REG_KILL, 18'hFFFF);
    write_reg(REG_DT, 18'd131072);
    write_reg(REG_COLS, 18'd5);
    write_reg(REG_ROWS, 18'd5);
    for (int i = 0; i < 25; i++) begin
      case (i % 5)
        0: begin pair.cell_u = -20'sd524288; pair.cell_v = 20'sd524287; end
        1: begin pair.cell_u = 20'sd524287;  pair.cell_v = -20'sd524288; end
        2: begin pair.cell_u = 20'sd65536;   pair.cell_v = 20'sd0; end
        3: begin pair.cell_u = 20'sd0;       pair.cell_v = 20'sd65536; end
        default: begin pair.cell_u = rand_value(); pair.cell_v = rand_value(); end
      endcase
      send_cell(pair);
    end
    wait_idle();

    // Unused register index must be ignored
    write_reg(REG_UNUSED, 18'h3FFFF);

    // Random phases on small grids, some cut short mid-frame
    for (int ph = 0; ph < 12; ph++) begin
      phase_no  = ph;
      idle_mode = idle_mode_e'(ph % 4);
      write_reg(REG_DIFF_U, rand_coef(16));
      write_reg(REG_DIFF_V, rand_coef(16));
      write_reg(REG_FEED, rand_coef(16));
      write_reg(REG_KILL, rand_coef(16));
      write_reg(REG_DT, (ph % 3 == 0) ? rand_coef(18) : CFG_DATA_W'($urandom_range(131072)));
      cols = (ph == 5) ? $urandom_range(2) : $urandom_range(3, 12);
      rows = (ph == 7) ? $urandom_range(2) : $urandom_range(3, 12);
      write_reg(REG_COLS, CFG_DATA_W'(cols));
      write_reg(REG_ROWS, CFG_DATA_W'(rows));
      sent = $urandom_range(60, 90);
      send_frame_cells(sent);
      wait_idle();
    end

    // Clamped sizes: too few columns and too many rows
    idle_mode = IDLE_BOTH;
    write_reg(REG_COLS, 18'd1);
    write_reg(REG_ROWS, 18'd2000);
    send_frame_cells(600);
    wait_idle();

    if (sb.mismatches == 0 && sb.pending_updates.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
